/* hdl/vsmm_pkg.sv */
// Shared constants and controller/datapath interface types for the vector statistics block.
package vsmm_pkg;

   // Sizing
   localparam int MAX_ELEMENTS   = 256;
   localparam int MEAN_FRAC_BITS = 16;

   // Fixed field widths
   localparam int ELEM_W   = 32;
   localparam int MEAN_W   = 48;
   localparam int NARROW_W = 9;

   // Derived widths
   localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int DIVD_W  = ELEM_W + MEAN_FRAC_BITS;
   localparam int DSTEP_W = $clog2(DIVD_W);
   localparam int QX_W    = (DIVD_W > MEAN_W) ? DIVD_W : MEAN_W;
   localparam int CX_W    = (CNT_W > NARROW_W) ? CNT_W : NARROW_W;

   // Stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 136;

   // Commands from controller to datapath
   typedef struct packed {
      logic ingest;     // store and accumulate the current element
      logic scan_init;  // clear outer index and best-so-far
      logic cand_rd;    // read candidate at outer index
      logic cand_ld;    // capture candidate, restart inner scan
      logic inner_rd;   // read element at inner index
      logic update;     // compare candidate count with best
      logic div_init;   // load divider
      logic div_step;   // one restoring-division step
      logic out_load;   // load result register and clear the vector
   } vsmm_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic j_last;
      logic i_last;
      logic div_done;
      logic out_free;
   } vsmm_sts_type;

endpackage

/* hdl/vsmm_ctrl.sv */
// Sequencer for element ingest, mode search, mean division and result hand-off.
module vsmm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  vsmm_pkg::vsmm_sts_type sts,
   output vsmm_pkg::vsmm_cmd_type cmd
);
   import vsmm_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CAND_RD = 3'd1;
   localparam logic [2:0] S_CAND_LD = 3'd2;
   localparam logic [2:0] S_INNER   = 3'd3;
   localparam logic [2:0] S_DRAIN   = 3'd4;
   localparam logic [2:0] S_UPDATE  = 3'd5;
   localparam logic [2:0] S_DIV     = 3'd6;
   localparam logic [2:0] S_OUT     = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       accept;

   // No transaction is taken while reset is high
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.ingest = 1'b1;
               if (req_tlast) begin
                  cmd.scan_init = 1'b1;
                  state_in      = S_CAND_RD;
               end
            end
         end
         S_CAND_RD: begin
            cmd.cand_rd = 1'b1;
            state_in    = S_CAND_LD;
         end
         S_CAND_LD: begin
            cmd.cand_ld = 1'b1;
            state_in    = S_INNER;
         end
         S_INNER: begin
            cmd.inner_rd = 1'b1;
            if (sts.j_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            if (sts.i_last) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_CAND_RD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/vsmm_datapath.sv */
// Element store, running sum, mode search counters, mean divider and result register.
module vsmm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [vsmm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  vsmm_pkg::vsmm_cmd_type              cmd,
   output vsmm_pkg::vsmm_sts_type              sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vsmm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import vsmm_pkg::*;

   // Element store
   logic [ELEM_W-1:0] mem [MAX_ELEMENTS];
   logic [ELEM_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  rd_addr;

   // Vector state
   logic [CNT_W-1:0]  cnt_ff;
   logic [ELEM_W-1:0] sum_ff;
   logic              ovf_ff;
   logic              drop_ff;

   // Mode search
   logic [CNT_W-1:0]  i_ff, j_ff, c_ff, best_freq_ff;
   logic [ELEM_W-1:0] cand_ff, best_val_ff;
   logic              cmp_vld_ff;

   // Divider
   logic [DIVD_W-1:0]  dvd_ff;
   logic [CNT_W-1:0]   rem_ff;
   logic [DSTEP_W-1:0] step_ff;
   logic [CNT_W:0]     rem_sh;
   logic               q_bit;
   logic [CNT_W:0]     rem_sub;

   // Result register
   logic              rsp_valid_ff;
   logic [ELEM_W-1:0] out_sum_ff, out_mode_ff;
   logic              out_ovf_ff, out_drop_ff;
   logic [MEAN_W-1:0] out_mean_ff;
   logic [NARROW_W-1:0] out_freq_ff, out_cnt_ff;

   logic [ELEM_W-1:0] elem;
   logic [ELEM_W-1:0] sum_add;
   logic              store_room;
   logic              sum_neg;
   logic [ELEM_W-1:0] sum_mag;
   logic [QX_W-1:0]   q_ext, q_signed;
   logic [CX_W-1:0]   freq_ext, cnt_ext;

   assign elem       = req_tdata[ELEM_W-1:0];
   assign sum_add    = sum_ff + elem;
   assign store_room = (cnt_ff < CNT_W'(MAX_ELEMENTS));
   assign rd_addr    = cmd.cand_rd ? i_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.ingest && store_room) begin
         mem[cnt_ff[IDX_W-1:0]] <= elem;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Count, wrapped sum and sticky flags
   always_ff @(posedge clock) begin
      if (reset || cmd.out_load) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         ovf_ff  <= 1'b0;
         drop_ff <= 1'b0;
      end else if (cmd.ingest) begin
         if (store_room) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            sum_ff <= sum_add;
            if (!(sum_ff[ELEM_W-1] ^ elem[ELEM_W-1]) &&
                (sum_add[ELEM_W-1] ^ elem[ELEM_W-1])) begin
               ovf_ff <= 1'b1;
            end
         end else begin
            drop_ff <= 1'b1;
         end
      end
   end

   // Mode search: outer candidate, inner count, best so far
   always_ff @(posedge clock) begin
      cmp_vld_ff <= cmd.inner_rd;
      if (cmd.scan_init) begin
         i_ff         <= '0;
         best_freq_ff <= '0;
         best_val_ff  <= '0;
      end
      if (cmd.cand_ld) begin
         cand_ff <= rdata_ff;
         j_ff    <= '0;
         c_ff    <= '0;
      end else begin
         if (cmd.inner_rd) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (cmp_vld_ff && (rdata_ff == cand_ff)) begin
            c_ff <= c_ff + CNT_W'(1);
         end
      end
      if (cmd.update) begin
         if (c_ff > best_freq_ff) begin
            best_freq_ff <= c_ff;
            best_val_ff  <= cand_ff;
         end
         i_ff <= i_ff + CNT_W'(1);
      end
   end

   assign sts.j_last = (j_ff == cnt_ff - CNT_W'(1));
   assign sts.i_last = (i_ff == cnt_ff - CNT_W'(1));

   // Restoring divider: magnitude of sum, scaled, over the count
   assign sum_neg = sum_ff[ELEM_W-1];
   assign sum_mag = sum_neg ? (~sum_ff + ELEM_W'(1)) : sum_ff;
   assign rem_sh  = {rem_ff, dvd_ff[DIVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, cnt_ff};
   assign q_bit   = (rem_sh >= {1'b0, cnt_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         dvd_ff  <= DIVD_W'(sum_mag) << MEAN_FRAC_BITS;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[DIVD_W-2:0], q_bit};
         rem_ff  <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         step_ff <= step_ff + DSTEP_W'(1);
      end
   end

   assign sts.div_done = (step_ff == DSTEP_W'(DIVD_W - 1));

   // Signed mean and narrowed counts
   assign q_ext    = QX_W'(dvd_ff);
   assign q_signed = sum_neg ? (~q_ext + QX_W'(1)) : q_ext;
   assign freq_ext = CX_W'(best_freq_ff);
   assign cnt_ext  = CX_W'(cnt_ff);

   // Result register, held until the transaction completes
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sum_ff  <= sum_ff;
         out_ovf_ff  <= ovf_ff;
         out_mean_ff <= q_signed[MEAN_W-1:0];
         out_mode_ff <= best_val_ff;
         out_freq_ff <= freq_ext[NARROW_W-1:0];
         out_cnt_ff  <= cnt_ext[NARROW_W-1:0];
         out_drop_ff <= drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, out_drop_ff, out_cnt_ff, out_freq_ff, out_mode_ff,
                        out_mean_ff, out_ovf_ff, out_sum_ff};

endmodule

/* hdl/vector_sum_mean_mode.sv */
// Top level: sum, mean and mode over a vector of signed 32-bit elements.
//
//  Channel | Dir | Handshake               | Contents
//  req     | in  | req_tvalid/req_tready   | tdata: element_value; tlast: last_element
//  rsp     | out | rsp_tvalid/rsp_tready   | tdata: statistics for one vector
//
//  Elements load one per cycle into the element store while ready is high.
//  After the element with tlast, the search for the mode runs over the n
//  stored elements (one store read per compare), then the mean divider runs,
//  one quotient bit per cycle, and the result register is loaded once the
//  output register is free; ready stays low meanwhile.
//  The result waits in an output register; new elements are taken while it
//  is held, and the next result waits until that transaction completes.
//  Reset is synchronous and clears the count, sum, flags and handshakes.
module vector_sum_mean_mode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] element_value
   input  logic [vsmm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] total_sum, [32] sum_overflowed, [80:33] mean_fixed,
   // [112:81] mode_value, [121:113] mode_frequency, [130:122] element_count,
   // [131] elements_dropped, [135:132] zero
   output logic [vsmm_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import vsmm_pkg::*;

   vsmm_cmd_type cmd;
   vsmm_sts_type sts;

   // Sequencer
   vsmm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Store, arithmetic and result register
   vsmm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
